/* hw/rtl/fractional_lif_neuron_step_unit_assert.svh */
// Assertion macros for the fractional LIF neuron step unit.
`ifndef FRACTIONAL_LIF_NEURON_STEP_UNIT_ASSERT_SVH
`define FRACTIONAL_LIF_NEURON_STEP_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, b)
`define ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

/* hw/rtl/fln_pkg.sv */
// Shared constants for the fractional LIF neuron step unit.
package fln_pkg;
	localparam int MAX_HIST = 1024;
	localparam int HIST_AW = $clog2(MAX_HIST);
	localparam int LEN_W = $clog2(MAX_HIST + 1);
	localparam int ACC_W = 50 + HIST_AW;
	localparam int CFG_IW = 3;

	localparam logic [1:0] FN_STEP = 2'd0;
	localparam logic [1:0] FN_LOAD = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_AFTER_SPIKE = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_REST = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_INV_TAU = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_DT_ALPHA = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_BIAS = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_HIST_LEN = 3'd6;
endpackage

/* hw/rtl/fln_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module fln_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* hw/rtl/fractional_lif_neuron_step_unit.sv */
// Top level of the fractional-order LIF neuron step unit.
// One neuron whose leak carries a memory term over past voltages. A step request
// holds off the next request until its result is written back; it walks K history
// terms, where K is the number of history terms in use (at most history_length - 1),
// and the write-back waits while an earlier result is still held, stalled, in the
// output register: a single multiply-accumulate unit walks the voltage history and
// coefficient memories, one read of each per cycle, and a short sequencer then forms
// the leak, drive and spike decision. Load and restart requests give no result. The
// result sits in an output register, so a finished voltage may wait there while the
// next request is accepted. Neither memory is cleared after reset; coefficients must
// be loaded before they are used.
`include "fractional_lif_neuron_step_unit_assert.svh"
module fractional_lif_neuron_step_unit
	import fln_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic signed [31:0]  input_current,
	input  logic [9:0]          coeff_index,
	input  logic signed [31:0]  coeff_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  membrane_voltage,
	output logic                spike
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREV = 3'd1;
	localparam logic [2:0] S_MAC  = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_RHS  = 3'd4;
	localparam logic [2:0] S_DRV  = 3'd5;
	localparam logic [2:0] S_SUM  = 3'd6;
	localparam logic [2:0] S_WB   = 3'd7;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	logic signed [31:0] thr_q, after_q, rest_q, bias_q;
	logic [30:0]        tau_q, dt_q;
	logic [10:0]        hlen_q;

	logic [2:0]         state_q;
	logic [HIST_AW-1:0] head_q;
	logic [LEN_W-1:0]   fill_q;

	logic [LEN_W-1:0]   len_q, fill_w_q, terms_q, kcnt_q;
	logic [HIST_AW-1:0] head_w_q, pos_q;
	logic signed [31:0] cur_q;
	logic signed [32:0] diff_q;
	logic signed [63:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-17:0] mem_q;
	logic signed [31:0] rhs_q, vsum_q;
	logic               rd_v_s1, prod_v_s2;
	logic signed [63:0] prod_s2;

	logic               out_valid_q, spk_q;
	logic signed [31:0] mv_q;

	logic [31:0]        hist_rdata, coeff_rdata;
	logic [HIST_AW-1:0] hist_raddr, prev_addr;
	logic [LEN_W-1:0]   len_n, fill_n;
	logic [HIST_AW-1:0] head_n;
	logic               accept, issue, out_free, coeff_we, do_spike;
	logic signed [31:0] vprev, v_final;
	logic signed [47:0] decay, drive;
	logic signed [49:0] rhs_sum;
	logic [LEN_W-1:0]   head_inc;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign issue = (kcnt_q <= terms_q);

	always_comb begin
		if (hlen_q == 11'd0) begin
			len_n = LEN_W'(1);
		end else if (32'(hlen_q) > MAX_HIST) begin
			len_n = LEN_W'(MAX_HIST);
		end else begin
			len_n = LEN_W'(hlen_q);
		end
		head_n = (LEN_W'(head_q) >= len_n) ? '0 : head_q;
		fill_n = (fill_q > len_n) ? len_n : fill_q;
		prev_addr = (head_n == '0) ? HIST_AW'(len_n - 1'b1) : head_n - 1'b1;
	end

	assign hist_raddr = (state_q == S_IDLE) ? prev_addr : pos_q;
	assign coeff_we = accept && (func == FN_LOAD) && (32'(coeff_index) < MAX_HIST);

	assign vprev = (fill_w_q != '0) ? $signed(hist_rdata) : rest_q;
	assign decay = 48'((prod_q + 64'sd32768) >>> 16);
	assign rhs_sum = 50'(cur_q) + 50'(bias_q) - 50'(decay);
	assign drive = 48'((prod_q + 64'sd32768) >>> 16);
	assign do_spike = (vsum_q >= thr_q);
	assign v_final = do_spike ? after_q : vsum_q;
	assign head_inc = LEN_W'(head_w_q) + 1'b1;

	fln_ram #(.WIDTH(32), .DEPTH(MAX_HIST)) u_hist_ram (
		.clk   (clk),
		.we    ((state_q == S_WB) && out_free),
		.waddr (head_w_q),
		.wdata (v_final),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	fln_ram #(.WIDTH(32), .DEPTH(MAX_HIST)) u_coeff_ram (
		.clk   (clk),
		.we    (coeff_we),
		.waddr (HIST_AW'(coeff_index)),
		.wdata (coeff_value),
		.raddr (kcnt_q[HIST_AW-1:0]),
		.rdata (coeff_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 32'sd65536;
			after_q <= '0;
			rest_q <= '0;
			tau_q <= 31'd65536;
			dt_q <= 31'd65536;
			bias_q <= '0;
			hlen_q <= 11'd1024;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD:   thr_q <= cfg_wdata;
				CFG_AFTER_SPIKE: after_q <= cfg_wdata;
				CFG_REST:        rest_q <= cfg_wdata;
				CFG_INV_TAU:     tau_q <= cfg_wdata[30:0];
				CFG_DT_ALPHA:    dt_q <= cfg_wdata[30:0];
				CFG_BIAS:        bias_q <= cfg_wdata;
				CFG_HIST_LEN:    hlen_q <= cfg_wdata[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			fill_q <= '0;
			rd_v_s1 <= 1'b0;
			prod_v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_WB)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (func)
							FN_STEP: state_q <= S_PREV;
							FN_RESTART: begin
								head_q <= '0;
								fill_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_PREV: state_q <= S_MAC;
				S_MAC: begin
					rd_v_s1 <= issue;
					prod_v_s2 <= rd_v_s1;
					if (!issue && !rd_v_s1 && !prod_v_s2) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: state_q <= S_RHS;
				S_RHS: state_q <= S_DRV;
				S_DRV: state_q <= S_SUM;
				S_SUM: state_q <= S_WB;
				S_WB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						head_q <= (head_inc == len_q) ? '0 : HIST_AW'(head_inc);
						fill_q <= (fill_w_q < len_q) ? fill_w_q + 1'b1 : fill_w_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			len_q <= len_n;
			head_w_q <= head_n;
			fill_w_q <= fill_n;
			terms_q <= (fill_n < len_n) ? fill_n : len_n - 1'b1;
			pos_q <= prev_addr;
			kcnt_q <= LEN_W'(1);
			cur_q <= input_current;
			acc_q <= '0;
		end
		if (state_q == S_PREV) begin
			diff_q <= 33'(vprev) - 33'(rest_q);
		end
		if (state_q == S_MAC) begin
			if (issue) begin
				kcnt_q <= kcnt_q + 1'b1;
				pos_q <= (pos_q == '0) ? HIST_AW'(len_q - 1'b1) : pos_q - 1'b1;
			end
			prod_s2 <= $signed(coeff_rdata) * $signed(hist_rdata);
			if (prod_v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2 >>> 14);
			end
		end
		if (state_q == S_DEC) begin
			prod_q <= diff_q * $signed({1'b0, tau_q});
			mem_q <= (ACC_W-16)'((acc_q + ACC_W'(32768)) >>> 16);
		end
		if (state_q == S_RHS) begin
			rhs_q <= sat32(64'(rhs_sum));
		end
		if (state_q == S_DRV) begin
			prod_q <= rhs_q * $signed({1'b0, dt_q});
		end
		if (state_q == S_SUM) begin
			vsum_q <= sat32(64'(drive) - 64'(mem_q));
		end
		if (state_q == S_WB && out_free) begin
			mv_q <= v_final;
			spk_q <= do_spike;
		end
	end

	assign out_valid = out_valid_q;
	assign membrane_voltage = mv_q;
	assign spike = spk_q;

	`ASSERT_NEXT(a_wb_hold, clk, arst_n, (state_q == S_WB) && out_valid_q && out_stall,
		state_q == S_WB)
	`ASSERT_NEXT(a_prod_follows_read, clk, arst_n, rd_v_s1, prod_v_s2)
	`ASSERT_IMPL(a_issue_bound, clk, arst_n, state_q == S_MAC, kcnt_q <= terms_q + 1'b1)
	`ASSERT_IMPL(a_wb_window, clk, arst_n, state_q == S_WB,
		(fill_w_q <= len_q) && (LEN_W'(head_w_q) < len_q))
endmodule

/* bench/tb_top.sv */
// Testbench for the fractional LIF neuron step unit: directed and random requests checked against an in-bench predictor.
`timescale 1ns / 1ps
module tb_top;
	import fln_pkg::*;

	localparam int ONE = 65536;
	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 16;
	localparam int END_CYCLES = 64;
	localparam longint TIMEOUT_NS = 64'd10_000_000;
	localparam int MAX_REPORTS = 30;

	typedef struct packed {
		logic signed [31:0] voltage;
		logic               spike;
	} neuron_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [31:0]         cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          func;
	logic signed [31:0]  input_current;
	logic [9:0]          coeff_index;
	logic signed [31:0]  coeff_value;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic signed [31:0]  membrane_voltage;
	logic                spike;

	fractional_lif_neuron_step_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.input_current    (input_current),
		.coeff_index      (coeff_index),
		.coeff_value      (coeff_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.membrane_voltage (membrane_voltage),
		.spike            (spike)
	);

	always #5 clk = ~clk;

	logic signed [31:0] thr_r;
	logic signed [31:0] after_r;
	logic signed [31:0] rest_r;
	logic [30:0]        inv_tau_r;
	logic [30:0]        dt_alpha_r;
	logic signed [31:0] bias_r;
	logic [10:0]        hist_len_r;

	longint      volt_hist [MAX_HIST];
	bit          volt_written [MAX_HIST];
	longint      coeff_mem [MAX_HIST];
	bit          coeff_loaded [MAX_HIST];
	int unsigned head_ptr;
	int unsigned fill_cnt;

	neuron_result_t results_due [$];
	neuron_result_t due_res;

	int error_count = 0;
	int n_steps = 0;
	int n_spikes = 0;
	int n_loads = 0;
	int n_restarts = 0;
	int n_ignored = 0;
	int n_settings = 0;
	int n_checked = 0;

	int stall_mode = 0;
	int stall_run = 0;
	bit stall_hold = 1'b0;
	bit idle_sender = 1'b0;
	int burst_left = 0;

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	function automatic longint round_q16(input longint v);
		return (v + 64'sd32768) >>> 16;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic int unsigned active_len();
		int unsigned l;
		l = hist_len_r;
		if (l == 0)
			l = 1;
		if (l > MAX_HIST)
			l = MAX_HIST;
		return l;
	endfunction

	function automatic int unsigned next_terms();
		int unsigned l;
		int unsigned fc;
		l = active_len();
		fc = (fill_cnt > l) ? l : fill_cnt;
		return (fc < l) ? fc : l - 1;
	endfunction

	function automatic bit history_readable();
		int unsigned l;
		int unsigned h;
		int unsigned fc;
		int unsigned k;
		l = active_len();
		h = (head_ptr >= l) ? 0 : head_ptr;
		fc = (fill_cnt > l) ? l : fill_cnt;
		if (fc > 0 && !volt_written[(h + l - 1) % l])
			return 1'b0;
		for (k = 1; k <= next_terms(); k++)
			if (!volt_written[(h + l - k) % l])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int unsigned missing_coeff();
		int unsigned k;
		for (k = 1; k <= next_terms(); k++)
			if (!coeff_loaded[k])
				return k;
		return 0;
	endfunction

	task automatic reset_model();
		thr_r = 32'sd65536;
		after_r = 32'sd0;
		rest_r = 32'sd0;
		inv_tau_r = 31'd65536;
		dt_alpha_r = 31'd65536;
		bias_r = 32'sd0;
		hist_len_r = 11'd1024;
		for (int i = 0; i < MAX_HIST; i++) begin
			volt_hist[i] = 0;
			volt_written[i] = 1'b0;
			coeff_mem[i] = 0;
			coeff_loaded[i] = 1'b0;
		end
		head_ptr = 0;
		fill_cnt = 0;
	endtask

	task automatic advance_neuron(input logic signed [31:0] cur);
		int unsigned l;
		int unsigned h;
		int unsigned terms;
		int unsigned k;
		longint vprev;
		longint acc;
		longint mem;
		longint decay;
		longint rhs;
		longint drive;
		longint v;
		neuron_result_t res;
		l = active_len();
		if (head_ptr >= l)
			head_ptr = 0;
		if (fill_cnt > l)
			fill_cnt = l;
		h = head_ptr;
		vprev = longint'(rest_r);
		if (fill_cnt > 0)
			vprev = volt_hist[(h + l - 1) % l];
		terms = (fill_cnt < l) ? fill_cnt : l - 1;
		acc = 0;
		for (k = 1; k <= terms; k++)
			acc += (coeff_mem[k] * volt_hist[(h + l - k) % l]) >>> 14;
		mem = round_q16(acc);
		decay = round_q16((vprev - longint'(rest_r)) * longint'(inv_tau_r));
		rhs = clamp32(longint'(cur) + longint'(bias_r) - decay);
		drive = round_q16(rhs * longint'(dt_alpha_r));
		v = clamp32(drive - mem);
		res.spike = 1'b0;
		if (v >= longint'(thr_r)) begin
			v = longint'(after_r);
			res.spike = 1'b1;
			n_spikes++;
		end
		res.voltage = v[31:0];
		volt_hist[h] = v;
		volt_written[h] = 1'b1;
		head_ptr = (h + 1) % l;
		if (fill_cnt < l)
			fill_cnt++;
		n_steps++;
		results_due.push_back(res);
	endtask

	task automatic apply_request(input logic [1:0] f, input logic signed [31:0] cur,
			input logic [9:0] ix, input logic signed [31:0] cv);
		case (f)
			FN_STEP: advance_neuron(cur);
			FN_LOAD: begin
				coeff_mem[ix] = longint'(cv);
				coeff_loaded[ix] = 1'b1;
				n_loads++;
			end
			FN_RESTART: begin
				fill_cnt = 0;
				head_ptr = 0;
				n_restarts++;
			end
			default: n_ignored++;
		endcase
	endtask

	task automatic send_request(input logic [1:0] f, input logic signed [31:0] cur,
			input logic [9:0] ix, input logic signed [31:0] cv);
		int gap;
		gap = 0;
		if (idle_sender) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
			end
			burst_left--;
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		input_current = cur;
		coeff_index = ix;
		coeff_value = cv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(f, cur, ix, cv);
	endtask

	function automatic logic [31:0] rand_span(input int unsigned span);
		int s;
		s = int'($urandom_range(0, 2 * span)) - int'(span);
		return s;
	endfunction

	function automatic logic [31:0] rand_current();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		if (r < 15)
			return $urandom;
		return rand_span(2 * ONE);
	endfunction

	function automatic logic [31:0] rand_coeff();
		int s;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		s = rand_span(32'h3FFF_FFFF);
		return s >>> $urandom_range(0, 6);
	endfunction

	task automatic issue_step(input logic [31:0] cur);
		int unsigned k;
		if (!history_readable())
			send_request(FN_RESTART, $urandom, $urandom, $urandom);
		k = missing_coeff();
		while (k != 0) begin
			send_request(FN_LOAD, $urandom, k[9:0], rand_coeff());
			k = missing_coeff();
		end
		send_request(FN_STEP, cur, $urandom, $urandom);
	endtask

	task automatic drain_results();
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		burst_left = 0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(posedge clk);
		case (idx)
			CFG_THRESHOLD:   thr_r = data;
			CFG_AFTER_SPIKE: after_r = data;
			CFG_REST:        rest_r = data;
			CFG_INV_TAU:     inv_tau_r = data[30:0];
			CFG_DT_ALPHA:    dt_alpha_r = data[30:0];
			CFG_BIAS:        bias_r = data;
			CFG_HIST_LEN:    hist_len_r = data[10:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] thr, input logic [31:0] aft,
			input logic [31:0] rst, input logic [31:0] tau, input logic [31:0] dta,
			input logic [31:0] bia, input logic [31:0] len);
		quiesce();
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_AFTER_SPIKE, aft);
		write_reg(CFG_REST, rst);
		write_reg(CFG_INV_TAU, tau);
		write_reg(CFG_DT_ALPHA, dta);
		write_reg(CFG_BIAS, bia);
		write_reg(CFG_HIST_LEN, len);
		@(negedge clk);
		cfg_we = 1'b0;
		n_settings++;
	endtask

	function automatic logic [31:0] rand_rate(input int unsigned lo, input int unsigned hi);
		logic [31:0] w;
		int unsigned r;
		w = $urandom;
		r = $urandom_range(0, 9);
		if (r == 0)
			w[30:0] = '0;
		else if (r == 1)
			w[30:0] = '1;
		else
			w[30:0] = $urandom_range(lo, hi);
		return w;
	endfunction

	task automatic random_settings();
		logic [31:0] thr;
		logic [31:0] aft;
		logic [31:0] rst;
		logic [31:0] bia;
		logic [31:0] len;
		int unsigned r;
		int unsigned l;
		r = $urandom_range(0, 9);
		if (r == 0)
			thr = 32'h7FFF_FFFF;
		else if (r == 1)
			thr = 32'h8000_0000;
		else
			thr = $urandom_range(ONE / 10, 3 * ONE);
		aft = ($urandom_range(0, 9) == 0) ? $urandom : rand_span(ONE);
		rst = ($urandom_range(0, 9) == 0) ? $urandom : rand_span(ONE / 2);
		bia = ($urandom_range(0, 9) == 0) ? $urandom : rand_span(ONE / 2);
		r = $urandom_range(0, 99);
		if (r < 15)
			l = r / 5;
		else if (r < 75)
			l = $urandom_range(3, 16);
		else
			l = $urandom_range(17, 48);
		len = l;
		if ($urandom_range(0, 1)) begin
			len = $urandom;
			len[10:0] = l;
		end
		apply_settings(thr, aft, rst, rand_rate(1000, 70000), rand_rate(5000, 80000), bia, len);
	endtask

	task automatic test_directed();
		stall_mode = 0;
		idle_sender = 1'b0;
		apply_settings(ONE, 0, 0, ONE / 2, ONE, 0, 8);
		send_request(FN_LOAD, 0, 10'd0, 32'h4000_0000);
		send_request(FN_LOAD, 0, 10'd1023, 32'hC000_0000);
		send_request(FN_LOAD, 0, 10'd1, 32'h8000_0000);
		send_request(FN_LOAD, 0, 10'd2, 32'h7FFF_FFFF);
		send_request(FN_LOAD, 0, 10'd3, 32'h0000_0000);
		send_request(FN_LOAD, 0, 10'd4, 32'hECCC_CCCD);
		issue_step(32'h7FFF_FFFF);
		issue_step(32'h8000_0000);
		issue_step(32'h0000_0000);
		issue_step(ONE);
		issue_step(32'hFFFF_0000);
		send_request(FN_UNUSED, 32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF);
		issue_step(ONE / 4);
		send_request(FN_RESTART, 32'h7FFF_FFFF, 10'h155, 32'h5555_5555);
		issue_step(ONE / 2);

		// zero length behaves as a single entry
		apply_settings(32'h7FFF_FFFF, 32'h8000_0000, -ONE, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 0);
		issue_step(32'h7FFF_FFFF);
		issue_step(32'h8000_0000);
		issue_step(32'h0000_0000);

		// shrink below the write position
		stall_mode = 1;
		apply_settings(2 * ONE, -(ONE / 2), ONE / 8, ONE / 10, ONE, ONE / 16, 16);
		repeat (7) issue_step(rand_span(2 * ONE));
		apply_settings(2 * ONE, -(ONE / 2), ONE / 8, ONE / 10, ONE, ONE / 16, 4);
		repeat (3) issue_step(rand_span(2 * ONE));
	endtask

	task automatic test_random_phases();
		int unsigned r;
		for (int p = 0; p < 20; p++) begin
			stall_mode = $urandom_range(0, 2);
			idle_sender = ($urandom_range(0, 3) != 0);
			random_settings();
			for (int i = 0; i < 24; i++) begin
				r = $urandom_range(0, 99);
				if (r < 78)
					issue_step(rand_current());
				else if (r < 88)
					send_request(FN_LOAD, $urandom,
						($urandom_range(0, 9) < 7) ? $urandom_range(1, 48) : $urandom,
						rand_coeff());
				else if (r < 93)
					send_request(FN_RESTART, $urandom, $urandom, $urandom);
				else if (r < 97)
					send_request(FN_UNUSED, $urandom, $urandom, $urandom);
				else begin
					@(negedge clk);
					in_valid = 1'b0;
					burst_left = 0;
					drain_results();
				end
			end
		end
	endtask

	task automatic test_full_length();
		stall_mode = 1;
		idle_sender = 1'b1;
		apply_settings(ONE / 2, 0, 0, ONE / 8, ONE / 2, ONE / 16, 1024);
		repeat (30) issue_step(rand_current());
		send_request(FN_UNUSED, $urandom, $urandom, $urandom);
		stall_mode = 2;
		// length field above the store size clips to the full store
		apply_settings(ONE / 2, -ONE, ONE / 4, ONE / 8, ONE / 2, ONE / 16, 32'hFFFF_FFFF);
		repeat (12) issue_step(rand_current());
	endtask

	always @(negedge clk) begin
		if (stall_mode == 0)
			out_stall = 1'b0;
		else if (stall_mode == 1)
			out_stall = ($urandom_range(0, 3) == 0);
		else begin
			if (stall_run == 0) begin
				stall_hold = !stall_hold;
				stall_run = stall_hold ? $urandom_range(1, 30) : $urandom_range(1, 12);
			end
			stall_run--;
			out_stall = stall_hold;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0)
				report_mismatch($sformatf("unexpected result voltage %h spike %b",
					membrane_voltage, spike));
			else begin
				due_res = results_due.pop_front();
				n_checked++;
				if (membrane_voltage !== due_res.voltage)
					report_mismatch($sformatf("voltage %h, predicted %h (result %0d)",
						membrane_voltage, due_res.voltage, n_checked));
				if (spike !== due_res.spike)
					report_mismatch($sformatf("spike %b, predicted %b (result %0d)",
						spike, due_res.spike, n_checked));
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d results outstanding", results_due.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = FN_STEP;
		input_current = '0;
		coeff_index = '0;
		coeff_value = '0;
		reset_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phases();
		test_full_length();

		quiesce();
		repeat (END_CYCLES) @(posedge clk);
		if (results_due.size() != 0)
			report_mismatch($sformatf("%0d predicted results never arrived", results_due.size()));
		$display("covered %0d steps (%0d spikes, %0d results checked), %0d coefficient loads,",
			n_steps, n_spikes, n_checked, n_loads);
		$display("%0d restarts, %0d ignored requests over %0d register settings, %0d mismatches",
			n_restarts, n_ignored, n_settings, error_count);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/fln_pkg.sv
hw/rtl/fln_ram.sv
hw/rtl/fractional_lif_neuron_step_unit.sv
bench/tb_top.sv
